// ----- sv/lhss_pkg.sv -----
// Shared types and constants for the link heartbeat and sync supervisor.
package lhss_pkg;

    // Minimum payload byte count of a sync request or sync response
    localparam logic [7:0] SYNC_PAYLOAD_BYTES = 8'd5;

    // Input mode codes
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_PACKET = 1'b1;

    // Received packet kinds
    localparam logic [2:0] KIND_KEY_EVENT = 3'd0;
    localparam logic [2:0] KIND_KEY_STATE = 3'd1;
    localparam logic [2:0] KIND_PING      = 3'd2;
    localparam logic [2:0] KIND_PONG      = 3'd3;
    localparam logic [2:0] KIND_SYNC_REQ  = 3'd4;
    localparam logic [2:0] KIND_SYNC_RSP  = 3'd5;
    localparam logic [2:0] KIND_OTHER     = 3'd6;

    // Transmit request codes
    localparam logic [2:0] SEND_NONE = 3'd0;
    localparam logic [2:0] SEND_PING = 3'd1;
    localparam logic [2:0] SEND_PONG = 3'd2;
    localparam logic [2:0] SEND_SREQ = 3'd3;
    localparam logic [2:0] SEND_SRSP = 3'd4;

    // Sync status codes
    localparam logic [2:0] SYNC_NONE = 3'd0;
    localparam logic [2:0] SYNC_PEND = 3'd1;
    localparam logic [2:0] SYNC_OK   = 3'd2;
    localparam logic [2:0] SYNC_BAD  = 3'd3;
    localparam logic [2:0] SYNC_TOUT = 3'd4;

    // LED pattern codes
    localparam logic [1:0] LED_OFF  = 2'd0;
    localparam logic [1:0] LED_SLOW = 2'd1;
    localparam logic [1:0] LED_FAST = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MASTER_ROLE    = 3'd0;
    localparam logic [2:0] REG_LOCAL_PROTOCOL = 3'd1;
    localparam logic [2:0] REG_LOCAL_ROWS     = 3'd2;
    localparam logic [2:0] REG_LOCAL_COLS     = 3'd3;
    localparam logic [2:0] REG_HB_PERIOD      = 3'd4;
    localparam logic [2:0] REG_SYNC_WAIT      = 3'd5;
    localparam logic [2:0] REG_LINK_WAIT      = 3'd6;

    localparam logic [15:0] TIMER_MAX = 16'hFFFF;

    typedef struct packed {
        logic        master_role;
        logic [7:0]  local_protocol_version;
        logic [7:0]  local_rows;
        logic [7:0]  local_cols;
        logic [15:0] heartbeat_period;
        logic [15:0] sync_wait_limit;
        logic [15:0] link_wait_limit;
    } cfg_t;

    typedef struct packed {
        logic        mode;
        logic [2:0]  packet_kind;
        logic [7:0]  payload_length;
        logic [7:0]  peer_protocol_version;
        logic [15:0] peer_firmware_version;
        logic [7:0]  peer_rows;
        logic [7:0]  peer_cols;
    } item_t;

    typedef struct packed {
        logic        connected;
        logic [2:0]  sync_state;
        logic [15:0] ticks_since_rx;
        logic [15:0] ticks_since_beat;
        logic [15:0] ticks_since_sync;
        logic [7:0]  peer_protocol;
        logic [15:0] peer_firmware;
    } state_t;

    typedef struct packed {
        logic [2:0]  send_request;
        logic        link_up;
        logic [2:0]  sync_state;
        logic [1:0]  led_pattern;
        logic [7:0]  remote_protocol;
        logic [15:0] remote_firmware;
    } result_t;

endpackage

// ----- sv/lhss_core.sv -----
// Next-state and result logic for one tick or packet item.
module lhss_core (
    input  lhss_pkg::cfg_t    cfg,
    input  lhss_pkg::state_t  state_cur,
    input  lhss_pkg::item_t   item,
    output lhss_pkg::state_t  state_next,
    output lhss_pkg::result_t result
);

    lhss_pkg::state_t st;
    logic [2:0]       send;
    logic             long_enough;
    logic             match;

    // Saturating timer increment
    function automatic logic [15:0] count_up(input logic [15:0] v);
        count_up = (v == lhss_pkg::TIMER_MAX) ? v : v + 16'd1;
    endfunction

    assign long_enough = (item.payload_length >= lhss_pkg::SYNC_PAYLOAD_BYTES);
    assign match = (item.peer_protocol_version == cfg.local_protocol_version) &&
                   (item.peer_rows == cfg.local_rows) &&
                   (item.peer_cols == cfg.local_cols);

    // Update state for a tick or a packet
    always_comb begin
        st   = state_cur;
        send = lhss_pkg::SEND_NONE;
        if (item.mode == lhss_pkg::MODE_TICK) begin
            st.ticks_since_rx   = count_up(state_cur.ticks_since_rx);
            st.ticks_since_beat = count_up(state_cur.ticks_since_beat);
            st.ticks_since_sync = count_up(state_cur.ticks_since_sync);
            if (cfg.master_role) begin
                // Master heartbeat: sync request when linked and unsynced, else ping
                if (st.ticks_since_beat >= cfg.heartbeat_period) begin
                    st.ticks_since_beat = '0;
                    if (st.connected && st.sync_state == lhss_pkg::SYNC_NONE) begin
                        send                = lhss_pkg::SEND_SREQ;
                        st.sync_state       = lhss_pkg::SYNC_PEND;
                        st.ticks_since_sync = '0;
                    end else begin
                        send = lhss_pkg::SEND_PING;
                    end
                end
                if (st.sync_state == lhss_pkg::SYNC_PEND &&
                    st.ticks_since_sync >= cfg.sync_wait_limit) begin
                    st.sync_state = lhss_pkg::SYNC_TOUT;
                end
            end
            // Drop a silent link
            if (st.connected && st.ticks_since_rx > cfg.link_wait_limit) begin
                st.connected  = 1'b0;
                st.sync_state = lhss_pkg::SYNC_NONE;
            end
        end else begin
            st.ticks_since_rx = '0;
            if (!st.connected) begin
                st.connected = 1'b1;
                if (cfg.master_role) begin
                    st.sync_state = lhss_pkg::SYNC_NONE;
                end
            end
            // Role-dependent packet handling
            if (item.packet_kind == lhss_pkg::KIND_PING && !cfg.master_role) begin
                send = lhss_pkg::SEND_PONG;
            end else if ((item.packet_kind == lhss_pkg::KIND_SYNC_REQ && !cfg.master_role &&
                          long_enough) ||
                         (item.packet_kind == lhss_pkg::KIND_SYNC_RSP && cfg.master_role &&
                          long_enough)) begin
                st.peer_protocol = item.peer_protocol_version;
                st.peer_firmware = item.peer_firmware_version;
                st.sync_state    = match ? lhss_pkg::SYNC_OK : lhss_pkg::SYNC_BAD;
                if (!cfg.master_role) begin
                    send = lhss_pkg::SEND_SRSP;
                end
            end
        end
    end

    // Build the result from the updated state
    always_comb begin
        state_next             = st;
        result.send_request    = send;
        result.link_up         = st.connected;
        result.sync_state      = st.sync_state;
        result.remote_protocol = st.peer_protocol;
        result.remote_firmware = st.peer_firmware;
        if (!st.connected) begin
            result.led_pattern = lhss_pkg::LED_SLOW;
        end else if (st.sync_state == lhss_pkg::SYNC_BAD) begin
            result.led_pattern = lhss_pkg::LED_FAST;
        end else begin
            result.led_pattern = lhss_pkg::LED_OFF;
        end
    end

endmodule

// ----- sv/link_heartbeat_sync_supervisor.sv -----
// Top level of the link heartbeat and sync supervisor: input register, core, result register.
//
//  Channel  Ports                               Handshake
//  -------  ----------------------------------  ------------------------------
//  input    s_valid s_ready s_mode ... s_peer_* transfer when s_valid & s_ready
//  result   m_valid m_ready m_send_request ...  transfer when m_valid & m_ready
//  config   cfg_we cfg_index cfg_wdata          write when cfg_we
//
// One item per cycle sustained while m_ready stays high; m_valid rises as the item moves
// from the input register to the result register, and the state is updated on that hop.
// Reset (aresetn low, synchronous) empties both registers, clears the link state
// and loads the configuration defaults.
// A stalled result holds the result register; the input register still takes
// one more item, then s_ready drops until the result moves.
module link_heartbeat_sync_supervisor (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [2:0]  s_packet_kind,
    input  logic [7:0]  s_payload_length,
    input  logic [7:0]  s_peer_protocol_version,
    input  logic [15:0] s_peer_firmware_version,
    input  logic [7:0]  s_peer_rows,
    input  logic [7:0]  s_peer_cols,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_send_request,
    output logic        m_link_up,
    output logic [2:0]  m_sync_state,
    output logic [1:0]  m_led_pattern,
    output logic [7:0]  m_remote_protocol,
    output logic [15:0] m_remote_firmware
);

    lhss_pkg::cfg_t    cfg_reg;
    lhss_pkg::state_t  state_reg;
    lhss_pkg::state_t  state_next;
    lhss_pkg::item_t   in_item_reg;
    lhss_pkg::result_t out_reg;
    lhss_pkg::result_t result_next;
    logic              in_valid_reg;
    logic              out_valid_reg;
    logic              advance;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.master_role            <= 1'b1;
            cfg_reg.local_protocol_version <= 8'd1;
            cfg_reg.local_rows             <= 8'd5;
            cfg_reg.local_cols             <= 8'd7;
            cfg_reg.heartbeat_period       <= 16'd100;
            cfg_reg.sync_wait_limit        <= 16'd500;
            cfg_reg.link_wait_limit        <= 16'd500;
        end else if (cfg_we) begin
            unique case (cfg_index)
                lhss_pkg::REG_MASTER_ROLE:    cfg_reg.master_role <= cfg_wdata[0];
                lhss_pkg::REG_LOCAL_PROTOCOL: cfg_reg.local_protocol_version <= cfg_wdata[7:0];
                lhss_pkg::REG_LOCAL_ROWS:     cfg_reg.local_rows <= cfg_wdata[7:0];
                lhss_pkg::REG_LOCAL_COLS:     cfg_reg.local_cols <= cfg_wdata[7:0];
                lhss_pkg::REG_HB_PERIOD:      cfg_reg.heartbeat_period <= cfg_wdata;
                lhss_pkg::REG_SYNC_WAIT:      cfg_reg.sync_wait_limit <= cfg_wdata;
                lhss_pkg::REG_LINK_WAIT:      cfg_reg.link_wait_limit <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance the held item when the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.mode                  <= s_mode;
            in_item_reg.packet_kind           <= s_packet_kind;
            in_item_reg.payload_length        <= s_payload_length;
            in_item_reg.peer_protocol_version <= s_peer_protocol_version;
            in_item_reg.peer_firmware_version <= s_peer_firmware_version;
            in_item_reg.peer_rows             <= s_peer_rows;
            in_item_reg.peer_cols             <= s_peer_cols;
        end
    end

    lhss_core u_core (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (in_item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Link state commits as the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_send_request    = out_reg.send_request;
    assign m_link_up         = out_reg.link_up;
    assign m_sync_state      = out_reg.sync_state;
    assign m_led_pattern     = out_reg.led_pattern;
    assign m_remote_protocol = out_reg.remote_protocol;
    assign m_remote_firmware = out_reg.remote_firmware;

endmodule

// ----- tb/sv/tb_link_heartbeat_sync_supervisor.sv -----
// Self-checking testbench for the link heartbeat and sync supervisor.
`timescale 1ns / 100ps

module tb_link_heartbeat_sync_supervisor;

    // Packet kind with no meaning on the link
    localparam logic [2:0] KIND_UNDEFINED = 3'd7;
    localparam int RANDOM_PHASES = 8;
    localparam int ITEMS_PER_PHASE = 135;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [2:0]  s_packet_kind;
    logic [7:0]  s_payload_length;
    logic [7:0]  s_peer_protocol_version;
    logic [15:0] s_peer_firmware_version;
    logic [7:0]  s_peer_rows;
    logic [7:0]  s_peer_cols;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_send_request;
    logic        m_link_up;
    logic [2:0]  m_sync_state;
    logic [1:0]  m_led_pattern;
    logic [7:0]  m_remote_protocol;
    logic [15:0] m_remote_firmware;

    // Supervisor state and settings as the testbench tracks them
    lhss_pkg::cfg_t    link_cfg;
    lhss_pkg::state_t  link_st;
    lhss_pkg::result_t pending_results[$];

    bit          idling_on;
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned mismatch_count;
    int unsigned stall_left;

    link_heartbeat_sync_supervisor dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cfg_we                  (cfg_we),
        .cfg_index               (cfg_index),
        .cfg_wdata               (cfg_wdata),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_mode                  (s_mode),
        .s_packet_kind           (s_packet_kind),
        .s_payload_length        (s_payload_length),
        .s_peer_protocol_version (s_peer_protocol_version),
        .s_peer_firmware_version (s_peer_firmware_version),
        .s_peer_rows             (s_peer_rows),
        .s_peer_cols             (s_peer_cols),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_send_request          (m_send_request),
        .m_link_up               (m_link_up),
        .m_sync_state            (m_sync_state),
        .m_led_pattern           (m_led_pattern),
        .m_remote_protocol       (m_remote_protocol),
        .m_remote_firmware       (m_remote_firmware)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Timer step that holds at full scale
    function automatic logic [15:0] count_sat(logic [15:0] v);
        return (v == lhss_pkg::TIMER_MAX) ? v : v + 16'd1;
    endfunction

    // Store peer versions and grade them against the local settings
    function automatic void note_peer(lhss_pkg::item_t it);
        link_st.peer_protocol = it.peer_protocol_version;
        link_st.peer_firmware = it.peer_firmware_version;
        if (it.peer_protocol_version == link_cfg.local_protocol_version &&
            it.peer_rows == link_cfg.local_rows && it.peer_cols == link_cfg.local_cols) begin
            link_st.sync_state = lhss_pkg::SYNC_OK;
        end else begin
            link_st.sync_state = lhss_pkg::SYNC_BAD;
        end
    endfunction

    // Advance the tracked state by one item and return the result it gives
    function automatic lhss_pkg::result_t supervise_item(lhss_pkg::item_t it);
        lhss_pkg::result_t r;
        logic              long_enough;
        r.send_request = lhss_pkg::SEND_NONE;
        long_enough = (it.payload_length >= lhss_pkg::SYNC_PAYLOAD_BYTES);
        if (it.mode == lhss_pkg::MODE_TICK) begin
            link_st.ticks_since_rx   = count_sat(link_st.ticks_since_rx);
            link_st.ticks_since_beat = count_sat(link_st.ticks_since_beat);
            link_st.ticks_since_sync = count_sat(link_st.ticks_since_sync);
            if (link_cfg.master_role) begin
                if (link_st.ticks_since_beat >= link_cfg.heartbeat_period) begin
                    link_st.ticks_since_beat = '0;
                    if (link_st.connected && link_st.sync_state == lhss_pkg::SYNC_NONE) begin
                        r.send_request = lhss_pkg::SEND_SREQ;
                        link_st.sync_state = lhss_pkg::SYNC_PEND;
                        link_st.ticks_since_sync = '0;
                    end else begin
                        r.send_request = lhss_pkg::SEND_PING;
                    end
                end
                if (link_st.sync_state == lhss_pkg::SYNC_PEND &&
                    link_st.ticks_since_sync >= link_cfg.sync_wait_limit) begin
                    link_st.sync_state = lhss_pkg::SYNC_TOUT;
                end
            end
            // Drop a silent link
            if (link_st.connected && link_st.ticks_since_rx > link_cfg.link_wait_limit) begin
                link_st.connected = 1'b0;
                link_st.sync_state = lhss_pkg::SYNC_NONE;
            end
        end else begin
            link_st.ticks_since_rx = '0;
            if (!link_st.connected) begin
                link_st.connected = 1'b1;
                if (link_cfg.master_role) begin
                    link_st.sync_state = lhss_pkg::SYNC_NONE;
                end
            end
            if (it.packet_kind == lhss_pkg::KIND_PING && !link_cfg.master_role) begin
                r.send_request = lhss_pkg::SEND_PONG;
            end else if (it.packet_kind == lhss_pkg::KIND_SYNC_REQ && !link_cfg.master_role &&
                         long_enough) begin
                note_peer(it);
                r.send_request = lhss_pkg::SEND_SRSP;
            end else if (it.packet_kind == lhss_pkg::KIND_SYNC_RSP && link_cfg.master_role &&
                         long_enough) begin
                note_peer(it);
            end
        end
        r.link_up = link_st.connected;
        r.sync_state = link_st.sync_state;
        if (!link_st.connected) begin
            r.led_pattern = lhss_pkg::LED_SLOW;
        end else if (link_st.sync_state == lhss_pkg::SYNC_BAD) begin
            r.led_pattern = lhss_pkg::LED_FAST;
        end else begin
            r.led_pattern = lhss_pkg::LED_OFF;
        end
        r.remote_protocol = link_st.peer_protocol;
        r.remote_firmware = link_st.peer_firmware;
        return r;
    endfunction

    function automatic lhss_pkg::item_t make_item(logic mode, logic [2:0] kind, logic [7:0] len,
                                                  logic [7:0] proto, logic [15:0] fw,
                                                  logic [7:0] rows, logic [7:0] cols);
        lhss_pkg::item_t it;
        it.mode = mode;
        it.packet_kind = kind;
        it.payload_length = len;
        it.peer_protocol_version = proto;
        it.peer_firmware_version = fw;
        it.peer_rows = rows;
        it.peer_cols = cols;
        return it;
    endfunction

    // Tick with random content in the unused fields
    function automatic lhss_pkg::item_t tick_item();
        return make_item(lhss_pkg::MODE_TICK, 3'($urandom_range(0, 7)), 8'($urandom),
                         8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    // Random item; packets lean toward sync traffic with matching fields
    function automatic lhss_pkg::item_t random_item(int unsigned tick_pct);
        lhss_pkg::item_t it;
        int unsigned     pick;
        it = tick_item();
        if ($urandom_range(0, 99) < tick_pct) begin
            return it;
        end
        it.mode = lhss_pkg::MODE_PACKET;
        pick = $urandom_range(0, 9);
        if (link_st.sync_state == lhss_pkg::SYNC_PEND && $urandom_range(0, 9) < 7) begin
            it.packet_kind = lhss_pkg::KIND_SYNC_RSP;
        end else if (pick < 3) begin
            it.packet_kind = lhss_pkg::KIND_SYNC_RSP;
        end else if (pick < 6) begin
            it.packet_kind = lhss_pkg::KIND_SYNC_REQ;
        end else if (pick < 8) begin
            it.packet_kind = lhss_pkg::KIND_PING;
        end
        if ($urandom_range(0, 4) == 0) begin
            it.payload_length = 8'($urandom_range(0, lhss_pkg::SYNC_PAYLOAD_BYTES - 1));
        end else begin
            it.payload_length = 8'($urandom_range(lhss_pkg::SYNC_PAYLOAD_BYTES, 255));
        end
        if ($urandom_range(0, 1)) begin
            it.peer_protocol_version = link_cfg.local_protocol_version;
            it.peer_rows = link_cfg.local_rows;
            it.peer_cols = link_cfg.local_cols;
        end
        return it;
    endfunction

    // Present one item and hold it until the transfer
    task automatic send_item(input lhss_pkg::item_t it);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= it.mode;
        s_packet_kind <= it.packet_kind;
        s_payload_length <= it.payload_length;
        s_peer_protocol_version <= it.peer_protocol_version;
        s_peer_firmware_version <= it.peer_firmware_version;
        s_peer_rows <= it.peer_rows;
        s_peer_cols <= it.peer_cols;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(supervise_item(it));
        items_sent++;
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Let the block go idle, then load every register
    task automatic apply_config(input lhss_pkg::cfg_t c);
        wait_results_drained();
        repeat (3) @(posedge aclk);
        write_reg(lhss_pkg::REG_MASTER_ROLE, {15'd0, c.master_role});
        write_reg(lhss_pkg::REG_LOCAL_PROTOCOL, {8'd0, c.local_protocol_version});
        write_reg(lhss_pkg::REG_LOCAL_ROWS, {8'd0, c.local_rows});
        write_reg(lhss_pkg::REG_LOCAL_COLS, {8'd0, c.local_cols});
        write_reg(lhss_pkg::REG_HB_PERIOD, c.heartbeat_period);
        write_reg(lhss_pkg::REG_SYNC_WAIT, c.sync_wait_limit);
        write_reg(lhss_pkg::REG_LINK_WAIT, c.link_wait_limit);
        cfg_we <= 1'b0;
        link_cfg = c;
    endtask

    // Master: handshake, short and long sync responses, mismatch, ping, drop, reconnect, new sync request
    task automatic test_master_handshake();
        apply_config('{master_role: 1'b1, local_protocol_version: 8'd1, local_rows: 8'd5,
                       local_cols: 8'd7, heartbeat_period: 16'd2, sync_wait_limit: 16'd2,
                       link_wait_limit: 16'd3});
        send_item(tick_item());
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_OTHER,
                            8'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        send_item(tick_item());
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_SYNC_RSP,
                            8'd4, 8'd1, 16'h1234, 8'd5, 8'd7));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_SYNC_RSP,
                            8'd5, 8'd1, 16'h1234, 8'd5, 8'd7));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_SYNC_RSP,
                            8'd255, 8'd255, 16'hFFFF, 8'd0, 8'd255));
        repeat (4) send_item(tick_item());
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_PING,
                            8'd3, 8'd0, 16'd0, 8'd0, 8'd0));
        repeat (3) send_item(tick_item());
    endtask

    // Slave: pong, sync response, short request, wrong-role and ignored kinds
    task automatic test_slave_replies();
        apply_config('{master_role: 1'b0, local_protocol_version: 8'd0, local_rows: 8'd255,
                       local_cols: 8'd0, heartbeat_period: 16'd65535,
                       sync_wait_limit: 16'd65535, link_wait_limit: 16'd0});
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_PING,
                            8'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_SYNC_REQ,
                            8'd5, 8'd0, 16'h0000, 8'd255, 8'd0));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_SYNC_REQ,
                            8'd4, 8'd9, 16'hA5A5, 8'd1, 8'd1));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_SYNC_RSP,
                            8'd5, 8'd9, 16'h5A5A, 8'd1, 8'd1));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_KEY_EVENT,
                            8'd1, 8'd0, 16'd0, 8'd0, 8'd0));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_KEY_STATE,
                            8'd2, 8'd0, 16'd0, 8'd0, 8'd0));
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_PONG,
                            8'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        send_item(make_item(lhss_pkg::MODE_PACKET, KIND_UNDEFINED,
                            8'd5, 8'd0, 16'd0, 8'd255, 8'd0));
        send_item(tick_item());
    endtask

    // Master with the shortest period and a zero sync wait
    task automatic test_extreme_limits();
        apply_config('{master_role: 1'b1, local_protocol_version: 8'd255, local_rows: 8'd0,
                       local_cols: 8'd255, heartbeat_period: 16'd1, sync_wait_limit: 16'd0,
                       link_wait_limit: 16'd65534});
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_OTHER,
                            8'd7, 8'd0, 16'd0, 8'd0, 8'd0));
        send_item(tick_item());
    endtask

    // Let the timers run in the slave role, then switch to master without clearing state
    task automatic test_role_switch();
        lhss_pkg::cfg_t c;
        c = '{master_role: 1'b0, local_protocol_version: 8'd1, local_rows: 8'd5,
              local_cols: 8'd7, heartbeat_period: 16'd65535, sync_wait_limit: 16'd65535,
              link_wait_limit: 16'd65534};
        idling_on = 1'b0;
        apply_config(c);
        send_item(make_item(lhss_pkg::MODE_PACKET, lhss_pkg::KIND_OTHER,
                            8'd0, 8'd0, 16'd0, 8'd0, 8'd0));
        repeat (40) send_item(tick_item());
        c.master_role = 1'b1;
        c.heartbeat_period = 16'd30;
        apply_config(c);
        repeat (3) send_item(tick_item());
    endtask

    // Random phases over both roles with short timers
    task automatic test_random_phases();
        lhss_pkg::cfg_t c;
        int unsigned    tick_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            c.master_role = (phase % 2 == 0) ? 1'b1 : 1'b0;
            c.local_protocol_version = 8'($urandom_range(0, 255));
            c.local_rows = 8'($urandom_range(0, 255));
            c.local_cols = 8'($urandom_range(0, 255));
            c.heartbeat_period = 16'($urandom_range(1, 8));
            c.sync_wait_limit = 16'($urandom_range(0, 8));
            c.link_wait_limit = 16'($urandom_range(0, 12));
            idling_on = (phase < RANDOM_PHASES - 2) && (phase != 2);
            tick_pct = $urandom_range(40, 85);
            apply_config(c);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the sender until the block has caught up
                if ((phase == 0 && n == 60) || $urandom_range(0, 149) == 0) begin
                    wait_results_drained();
                end
                send_item(random_item(tick_pct));
            end
        end
    endtask

    task automatic finish_run();
        wait_results_drained();
        repeat (8) @(posedge aclk);
        $display("%0d items sent, %0d results checked, %0d mismatches",
                 items_sent, results_checked, mismatch_count);
        $display("covered both roles, sync ok, mismatch and timeout, link drops, role switch");
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("tb_link_heartbeat_sync_supervisor: done, clean");
        end else begin
            $display("tb_link_heartbeat_sync_supervisor: done, errors");
        end
        $finish;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want != got) begin
            mismatch_count++;
            if (mismatch_count <= 200) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            end
        end
    endtask

    // Compare each result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        lhss_pkg::result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 200) begin
                    $display("%0t: result with no expectation, expected none actual send %0d",
                             $time, m_send_request);
                end
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("send_request", 16'(want.send_request), 16'(m_send_request));
                check_field("link_up", 16'(want.link_up), 16'(m_link_up));
                check_field("sync_state", 16'(want.sync_state), 16'(m_sync_state));
                check_field("led_pattern", 16'(want.led_pattern), 16'(m_led_pattern));
                check_field("remote_protocol", 16'(want.remote_protocol),
                            16'(m_remote_protocol));
                check_field("remote_firmware", want.remote_firmware, m_remote_firmware);
            end
        end
    end

    // Result side: random stall bursts while idling is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lhss_pkg::REG_MASTER_ROLE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_mode = lhss_pkg::MODE_TICK;
        s_packet_kind = lhss_pkg::KIND_KEY_EVENT;
        s_payload_length = '0;
        s_peer_protocol_version = '0;
        s_peer_firmware_version = '0;
        s_peer_rows = '0;
        s_peer_cols = '0;
        stall_left = 0;
        idling_on = 1'b1;
        link_cfg = '{master_role: 1'b1, local_protocol_version: 8'd1, local_rows: 8'd5,
                     local_cols: 8'd7, heartbeat_period: 16'd100, sync_wait_limit: 16'd500,
                     link_wait_limit: 16'd500};
        link_st = '0;
        link_st.sync_state = lhss_pkg::SYNC_NONE;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_master_handshake();
        test_slave_replies();
        test_extreme_limits();
        test_role_switch();
        test_random_phases();
        finish_run();
    end

    initial begin
        #10_000_000;
        $display("tb_link_heartbeat_sync_supervisor: done, errors");
        $finish;
    end

endmodule
